>>> rtl/lswc_pkg.sv
package lswc_pkg;

   // coordinate width of every field and window register
   localparam int COORD_BITS = 16;
   // magnitude bits of a p or q term (difference of two coordinates)
   localparam int QMAG_BITS = 16;
   localparam int T_FRACTION_BITS_DEFAULT = 16;

   localparam logic signed [COORD_BITS-1:0] WIN_X_MIN_RESET = 16'sd0;
   localparam logic signed [COORD_BITS-1:0] WIN_X_MAX_RESET = 16'sd639;
   localparam logic signed [COORD_BITS-1:0] WIN_Y_MIN_RESET = 16'sd0;
   localparam logic signed [COORD_BITS-1:0] WIN_Y_MAX_RESET = 16'sd479;

   typedef enum logic [1:0] {
      CSR_X_MIN = 2'd0,
      CSR_X_MAX = 2'd1,
      CSR_Y_MIN = 2'd2,
      CSR_Y_MAX = 2'd3
   } csr_index_type;

   // segment data and edge classification that ride along the divider
   typedef struct packed {
      logic signed [COORD_BITS-1:0] sx;
      logic signed [COORD_BITS-1:0] sy;
      logic signed [COORD_BITS-1:0] ex;
      logic signed [COORD_BITS-1:0] ey;
      logic [3:0]                   enter_mask;
      logic [3:0]                   leave_mask;
      logic                         reject;
   } seg_type;

endpackage

>>> rtl/lswc_if.sv
interface lswc_req_if;
   import lswc_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lswc_rsp_if;
   import lswc_pkg::*;
   logic                         valid;
   logic                         ready;
   logic                         visible;
   logic signed [COORD_BITS-1:0] clip_start_x;
   logic signed [COORD_BITS-1:0] clip_start_y;
   logic signed [COORD_BITS-1:0] clip_end_x;
   logic signed [COORD_BITS-1:0] clip_end_y;

   modport source (output valid, visible, clip_start_x, clip_start_y, clip_end_x,
                   clip_end_y, input ready);
   modport sink (input valid, visible, clip_start_x, clip_start_y, clip_end_x,
                 clip_end_y, output ready);
endinterface

>>> rtl/line_segment_window_clipper.sv
// An accepted req beat is registered through stage 0, the divider (one quotient bit
// per stage), C1, C2, D and E before it appears as its rsp beat.
// Throughput: one segment per cycle; the whole pipeline holds while rsp is stalled.
// Reset (synchronous, active high) clears all valid bits and loads the window
// registers with 0, 639, 0, 479.
module line_segment_window_clipper
   import lswc_pkg::*;
#(
   parameter int T_FRACTION_BITS = T_FRACTION_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   lswc_req_if.sink              req,
   lswc_rsp_if.source            rsp,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [COORD_BITS-1:0] csr_wdata
);

   localparam int F  = T_FRACTION_BITS;
   localparam int NW = QMAG_BITS + F;     // dividend / quotient width
   localparam int PW = F + 19;            // product width
   localparam int VW = F + 20;            // rounding sum width
   localparam logic [NW-1:0] T_ONE  = NW'(1) << F;
   localparam logic [VW-1:0] T_HALF = VW'(1) << (F - 1);

   // window registers
   logic signed [COORD_BITS-1:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff <= WIN_X_MIN_RESET;
         x_max_ff <= WIN_X_MAX_RESET;
         y_min_ff <= WIN_Y_MIN_RESET;
         y_max_ff <= WIN_Y_MAX_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_X_MIN: x_min_ff <= csr_wdata;
            CSR_X_MAX: x_max_ff <= csr_wdata;
            CSR_Y_MIN: y_min_ff <= csr_wdata;
            CSR_Y_MAX: y_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic adv;
   logic out_vld_ff;
   assign adv = !out_vld_ff || rsp.ready;
   assign req.ready = adv;

   // ---------------- stage 0: p/q terms and divider operands
   logic signed [16:0] p_s [4];
   logic signed [16:0] q_s [4];
   logic [15:0]        pmag [4];
   logic [15:0]        qmag [4];
   logic signed [16:0] dx_s, dy_s;
   seg_type            seg_in;

   always_comb begin
      dx_s = 17'(req.end_x) - 17'(req.start_x);
      dy_s = 17'(req.end_y) - 17'(req.start_y);
      p_s[0] = -dx_s;
      p_s[1] = dx_s;
      p_s[2] = -dy_s;
      p_s[3] = dy_s;
      q_s[0] = 17'(req.start_x) - 17'(x_min_ff);
      q_s[1] = 17'(x_max_ff) - 17'(req.start_x);
      q_s[2] = 17'(req.start_y) - 17'(y_min_ff);
      q_s[3] = 17'(y_max_ff) - 17'(req.start_y);
      seg_in.sx = req.start_x;
      seg_in.sy = req.start_y;
      seg_in.ex = req.end_x;
      seg_in.ey = req.end_y;
      seg_in.reject = 1'b0;
      for (int i = 0; i < 4; i++) begin
         qmag[i] = q_s[i][16] ? 16'(-q_s[i]) : q_s[i][15:0];
         // zero p never feeds a used quotient; divide by one to keep it tidy
         pmag[i] = (p_s[i] == '0) ? 16'd1 : (p_s[i][16] ? 16'(-p_s[i]) : p_s[i][15:0]);
         seg_in.enter_mask[i] = p_s[i][16] && q_s[i][16];
         seg_in.leave_mask[i] = !p_s[i][16] && (p_s[i] != '0) && !q_s[i][16];
         // parallel and outside, or exit below zero
         if (q_s[i][16] && !p_s[i][16]) seg_in.reject = 1'b1;
      end
   end

   // ---------------- divider: one restoring step per stage, four lanes
   logic          vld_ff [0:NW];
   seg_type       seg_ff [0:NW];
   logic [NW-1:0] num_ff [0:NW][4];
   logic [NW-1:0] quo_ff [0:NW][4];
   logic [15:0]   rem_ff [0:NW][4];
   logic [15:0]   den_ff [0:NW][4];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         seg_ff[0] <= seg_in;
         for (int i = 0; i < 4; i++) begin
            num_ff[0][i] <= {qmag[i], {F{1'b0}}};
            quo_ff[0][i] <= '0;
            rem_ff[0][i] <= '0;
            den_ff[0][i] <= pmag[i];
         end
      end
   end

   for (genvar k = 1; k <= NW; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            seg_ff[k] <= seg_ff[k-1];
         end
      end

      for (genvar ln = 0; ln < 4; ln++) begin : g_lane
         logic [16:0] trial;
         logic        fits;
         assign trial = {rem_ff[k-1][ln], num_ff[k-1][ln][NW-1]};
         assign fits  = trial >= {1'b0, den_ff[k-1][ln]};

         always_ff @(posedge clock) begin
            if (adv) begin
               num_ff[k][ln] <= {num_ff[k-1][ln][NW-2:0], 1'b0};
               quo_ff[k][ln] <= {quo_ff[k-1][ln][NW-2:0], fits};
               rem_ff[k][ln] <= fits ? 16'(trial - {1'b0, den_ff[k-1][ln]})
                                     : trial[15:0];
               den_ff[k][ln] <= den_ff[k-1][ln];
            end
         end
      end
   end

   // ---------------- C1: pairwise max of entry terms, min of exit terms
   logic [NW-1:0] tin_lane [4];
   logic [NW-1:0] tout_lane [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         tin_lane[i]  = seg_ff[NW].enter_mask[i] ? quo_ff[NW][i] : '0;
         tout_lane[i] = seg_ff[NW].leave_mask[i] ? quo_ff[NW][i] : T_ONE;
      end
   end

   logic          c1_vld_ff;
   seg_type       c1_seg_ff;
   logic [NW-1:0] c1_tin_a_ff, c1_tin_b_ff, c1_tout_a_ff, c1_tout_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_vld_ff <= 1'b0;
      end else if (adv) begin
         c1_vld_ff <= vld_ff[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_seg_ff    <= seg_ff[NW];
         c1_tin_a_ff  <= (tin_lane[0] > tin_lane[1]) ? tin_lane[0] : tin_lane[1];
         c1_tin_b_ff  <= (tin_lane[2] > tin_lane[3]) ? tin_lane[2] : tin_lane[3];
         c1_tout_a_ff <= (tout_lane[0] < tout_lane[1]) ? tout_lane[0] : tout_lane[1];
         c1_tout_b_ff <= (tout_lane[2] < tout_lane[3]) ? tout_lane[2] : tout_lane[3];
      end
   end

   // ---------------- C2: final entry and exit parameters, deltas
   logic               c2_vld_ff;
   seg_type            c2_seg_ff;
   logic [NW-1:0]      c2_tin_ff, c2_tout_ff;
   logic signed [16:0] c2_dx_ff, c2_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_vld_ff <= 1'b0;
      end else if (adv) begin
         c2_vld_ff <= c1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c2_seg_ff  <= c1_seg_ff;
         c2_tin_ff  <= (c1_tin_a_ff > c1_tin_b_ff) ? c1_tin_a_ff : c1_tin_b_ff;
         c2_tout_ff <= (c1_tout_a_ff < c1_tout_b_ff) ? c1_tout_a_ff : c1_tout_b_ff;
         c2_dx_ff   <= 17'(c1_seg_ff.ex) - 17'(c1_seg_ff.sx);
         c2_dy_ff   <= 17'(c1_seg_ff.ey) - 17'(c1_seg_ff.sy);
      end
   end

   // ---------------- D: rejection test and the four products
   logic signed [F+1:0] tin_s, tout_s;
   assign tin_s  = $signed({1'b0, c2_tin_ff[F:0]});
   assign tout_s = $signed({1'b0, c2_tout_ff[F:0]});

   logic                d_vld_ff;
   logic                d_ok_ff;
   logic                d_tin_zero_ff, d_tout_one_ff;
   seg_type             d_seg_ff;
   logic signed [PW-1:0] d_psx_ff, d_psy_ff, d_pex_ff, d_pey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         d_vld_ff <= c2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_seg_ff      <= c2_seg_ff;
         d_ok_ff       <= !c2_seg_ff.reject && (c2_tin_ff <= c2_tout_ff);
         d_tin_zero_ff <= (c2_tin_ff == '0);
         d_tout_one_ff <= (c2_tout_ff == T_ONE);
         d_psx_ff      <= PW'(tin_s * c2_dx_ff);
         d_psy_ff      <= PW'(tin_s * c2_dy_ff);
         d_pex_ff      <= PW'(tout_s * c2_dx_ff);
         d_pey_ff      <= PW'(tout_s * c2_dy_ff);
      end
   end

   // ---------------- E: round to nearest (floor of value plus half)
   function automatic logic signed [COORD_BITS-1:0] round_pt(
      input logic signed [COORD_BITS-1:0] base,
      input logic signed [PW-1:0]         prod
   );
      logic signed [VW-1:0] v;
      v = $signed({{4{base[COORD_BITS-1]}}, base, {F{1'b0}}})
        + $signed({prod[PW-1], prod}) + $signed(T_HALF);
      return v[F+COORD_BITS-1:F];
   endfunction

   logic                         vis_ff;
   logic signed [COORD_BITS-1:0] csx_ff, csy_ff, cex_ff, cey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vis_ff <= d_ok_ff;
         if (!d_ok_ff) begin
            csx_ff <= '0;
            csy_ff <= '0;
            cex_ff <= '0;
            cey_ff <= '0;
         end else begin
            csx_ff <= d_tin_zero_ff ? d_seg_ff.sx : round_pt(d_seg_ff.sx, d_psx_ff);
            csy_ff <= d_tin_zero_ff ? d_seg_ff.sy : round_pt(d_seg_ff.sy, d_psy_ff);
            cex_ff <= d_tout_one_ff ? d_seg_ff.ex : round_pt(d_seg_ff.sx, d_pex_ff);
            cey_ff <= d_tout_one_ff ? d_seg_ff.ey : round_pt(d_seg_ff.sy, d_pey_ff);
         end
      end
   end

   assign rsp.valid        = out_vld_ff;
   assign rsp.visible      = vis_ff;
   assign rsp.clip_start_x = csx_ff;
   assign rsp.clip_start_y = csy_ff;
   assign rsp.clip_end_x   = cex_ff;
   assign rsp.clip_end_y   = cey_ff;

   // ---------------- assertions
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> vld_ff[0])
      else $error("accepted req beat not captured");

   a_tout_bound: assert property (@(posedge clock) disable iff (reset)
      c2_vld_ff |-> c2_tout_ff <= T_ONE)
      else $error("exit parameter above one");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.visible |-> rsp.clip_start_x == '0 && rsp.clip_start_y == '0
         && rsp.clip_end_x == '0 && rsp.clip_end_y == '0)
      else $error("rejected segment with nonzero coordinates");

endmodule
